// ===== rtl/core/tcsl_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsl_pkg
// Shared types and constants of the three-channel sine LFO.
// ----------------------------------------------------------------------------
package tcsl_pkg;

   localparam int SAMPLE_BITS  = 12;
   localparam int IN_CHANNELS  = 3;
   localparam int CHAN_BITS    = 2;
   localparam int GAIN_BITS    = 21;
   localparam int MAG_BITS     = 12;

   localparam int MUL_A_BITS   = 2 * SAMPLE_BITS;
   localparam int MUL_B_BITS   = SAMPLE_BITS + 1;
   localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
   localparam int RATE_BITS    = MUL_B_BITS;

   localparam int CUBE_SHIFT   = 3 * SAMPLE_BITS - 12;
   localparam int SQUARE_SHIFT = 2 * SAMPLE_BITS - 14;
   localparam int SCALE_SHIFT  = 12;
   localparam int INC_BITS     = MUL_P_BITS - SCALE_SHIFT;

   localparam logic [GAIN_BITS-1:0]   GAIN_RESET = GAIN_BITS'(4096);
   localparam logic [SAMPLE_BITS-1:0] HALF_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
   localparam logic [SAMPLE_BITS-1:0] DAC_MID    = HALF_SCALE - SAMPLE_BITS'(1);
   localparam logic [MAG_BITS:0]      SINE_ONE   = (MAG_BITS + 1)'(2048);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_SQUARE_K,
      ST_CUBE_K,
      ST_SQUARE_V,
      ST_SCALE,
      ST_DELIVER
   } state_type;

   typedef struct packed {
      logic                  start;
      logic [MUL_A_BITS-1:0] a;
      logic [MUL_B_BITS-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic                  done;
      logic [MUL_P_BITS-1:0] product;
   } mul_rsp_type;

endpackage

// ===== rtl/core/tcsl_req_if.sv =====
// ----------------------------------------------------------------------------
// tcsl_req_if
// Frame tick channel carrying the knob and control-voltage readings.
// ----------------------------------------------------------------------------
interface tcsl_req_if;

   logic                            valid;
   logic                            ready;
   logic [tcsl_pkg::SAMPLE_BITS-1:0] knob_a;
   logic [tcsl_pkg::SAMPLE_BITS-1:0] knob_b;
   logic [tcsl_pkg::SAMPLE_BITS-1:0] knob_c;
   logic [tcsl_pkg::SAMPLE_BITS-1:0] volt_a;
   logic [tcsl_pkg::SAMPLE_BITS-1:0] volt_b;
   logic [tcsl_pkg::SAMPLE_BITS-1:0] volt_c;

   modport source (
      output valid, knob_a, knob_b, knob_c, volt_a, volt_b, volt_c,
      input  ready
   );

   modport sink (
      input  valid, knob_a, knob_b, knob_c, volt_a, volt_b, volt_c,
      output ready
   );

endinterface

// ===== rtl/core/tcsl_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tcsl_rsp_if
// Result channel carrying the DAC codes and LED states of one tick.
// ----------------------------------------------------------------------------
interface tcsl_rsp_if;

   logic                            valid;
   logic                            ready;
   logic [tcsl_pkg::SAMPLE_BITS-1:0] dac_a;
   logic [tcsl_pkg::SAMPLE_BITS-1:0] dac_b;
   logic [tcsl_pkg::SAMPLE_BITS-1:0] dac_c;
   logic                            led_a;
   logic                            led_b;
   logic                            led_c;

   modport source (
      output valid, dac_a, dac_b, dac_c, led_a, led_b, led_c,
      input  ready
   );

   modport sink (
      input  valid, dac_a, dac_b, dac_c, led_a, led_b, led_c,
      output ready
   );

endinterface

// ===== rtl/core/tcsl_serial_mul.sv =====
// ----------------------------------------------------------------------------
// tcsl_serial_mul
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tcsl_serial_mul (
   input  logic                  clock,
   input  logic                  reset,
   input  tcsl_pkg::mul_req_type mul_req,
   output tcsl_pkg::mul_rsp_type mul_rsp
);

   localparam int A_BITS     = tcsl_pkg::MUL_A_BITS;
   localparam int B_BITS     = tcsl_pkg::MUL_B_BITS;
   localparam int P_BITS     = tcsl_pkg::MUL_P_BITS;
   localparam int COUNT_BITS = $clog2(B_BITS);
   localparam logic [COUNT_BITS-1:0] LAST_STEP = COUNT_BITS'(B_BITS - 1);

   logic [A_BITS-1:0]     a_ff;
   logic [A_BITS-1:0]     a_in;
   logic [P_BITS-1:0]     prod_ff;
   logic [P_BITS-1:0]     prod_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  busy_ff;
   logic                  busy_in;
   logic                  done_ff;
   logic                  done_in;
   logic [A_BITS:0]       upper_sum;

   always_comb begin
      upper_sum = {1'b0, prod_ff[P_BITS-1:B_BITS]};
      if (prod_ff[0]) begin
         upper_sum = upper_sum + {1'b0, a_ff};
      end
   end

   always_comb begin
      a_in     = a_ff;
      prod_in  = prod_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (mul_req.start) begin
         a_in     = mul_req.a;
         prod_in  = {{A_BITS{1'b0}}, mul_req.b};
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in  = {upper_sum, prod_ff[B_BITS-1:1]};
         count_in = count_ff + COUNT_BITS'(1);
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      prod_ff <= prod_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = prod_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |=> busy_ff)
      else $error("Multiplier did not start.");

   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && count_ff == LAST_STEP && !mul_req.start) |=> (done_ff && !busy_ff))
      else $error("Multiplier did not finish after its last step.");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("Multiplier reported done while still busy.");

endmodule

// ===== rtl/core/tcsl_sine.sv =====
// ----------------------------------------------------------------------------
// tcsl_sine
// Quarter-wave sine lookup and conversion to a DAC code, three stages.
// ----------------------------------------------------------------------------
module tcsl_sine #(
   parameter int PHASE_BITS      = 24,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                             clock,
   input  logic                             start,
   input  logic [PHASE_BITS-1:0]            phase,
   output logic [tcsl_pkg::SAMPLE_BITS-1:0] dac_code
);

   localparam int ADDR_BITS = SINE_TABLE_BITS + 1;
   localparam int TABLE_N   = 1 << SINE_TABLE_BITS;
   localparam int MAG_BITS  = tcsl_pkg::MAG_BITS;
   localparam int SB        = tcsl_pkg::SAMPLE_BITS;
   localparam int DAC_WIDE  = MAG_BITS + 1 + SB;
   localparam logic [ADDR_BITS-1:0] TABLE_TOP = ADDR_BITS'(1) << SINE_TABLE_BITS;

   typedef logic [MAG_BITS-1:0] rom_type [TABLE_N + 1];

   function automatic rom_type build_rom();
      rom_type           rom;
      longint unsigned   theta;
      longint unsigned   theta2;
      longint unsigned   term;
      longint unsigned   mag;
      longint            sum;
      for (int i = 0; i <= TABLE_N; i++) begin
         theta  = (longint'(i) * 64'd1686629713) >> SINE_TABLE_BITS;
         theta2 = (theta * theta) >> 30;
         term   = theta;
         sum    = longint'(theta);
         term = ((term * theta2) >> 30) / 64'd6;
         sum  = sum - longint'(term);
         term = ((term * theta2) >> 30) / 64'd20;
         sum  = sum + longint'(term);
         term = ((term * theta2) >> 30) / 64'd42;
         sum  = sum - longint'(term);
         term = ((term * theta2) >> 30) / 64'd72;
         sum  = sum + longint'(term);
         term = ((term * theta2) >> 30) / 64'd110;
         sum  = sum - longint'(term);
         term = ((term * theta2) >> 30) / 64'd156;
         sum  = sum + longint'(term);
         term = ((term * theta2) >> 30) / 64'd210;
         sum  = sum - longint'(term);
         term = ((term * theta2) >> 30) / 64'd272;
         sum  = sum + longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         mag = (longint'(sum) * 64'd2048 + (64'd1 << 29)) >> 30;
         if (mag > 64'd2048) begin
            mag = 64'd2048;
         end
         rom[i] = MAG_BITS'(mag);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [1:0]               quad;
   logic [SINE_TABLE_BITS-1:0] slot;
   logic [ADDR_BITS-1:0]     addr_in;
   logic [ADDR_BITS-1:0]     addr_ff;
   logic                     neg_ff;
   logic                     neg_rom_ff;
   logic [MAG_BITS-1:0]      rom_ff;
   logic [MAG_BITS:0]        offset_sine;
   logic [DAC_WIDE-1:0]      dac_wide;
   logic [SB-1:0]            dac_ff;

   assign quad = phase[PHASE_BITS-1 -: 2];
   assign slot = phase[PHASE_BITS-3 -: SINE_TABLE_BITS];

   always_comb begin
      if (quad[0]) begin
         addr_in = TABLE_TOP - {1'b0, slot};
      end else begin
         addr_in = {1'b0, slot};
      end
   end

   always_comb begin
      if (neg_rom_ff) begin
         offset_sine = tcsl_pkg::SINE_ONE - {1'b0, rom_ff};
      end else begin
         offset_sine = tcsl_pkg::SINE_ONE + {1'b0, rom_ff};
      end
      dac_wide = DAC_WIDE'(offset_sine) * DAC_WIDE'(tcsl_pkg::DAC_MID);
   end

   always_ff @(posedge clock) begin
      if (start) begin
         addr_ff <= addr_in;
         neg_ff  <= quad[1];
      end
      rom_ff     <= SINE_ROM[addr_ff];
      neg_rom_ff <= neg_ff;
      dac_ff     <= dac_wide[11 +: SB];
   end

   assign dac_code = dac_ff;

endmodule

// ===== rtl/core/three_channel_sine_lfo.sv =====
// ----------------------------------------------------------------------------
// three_channel_sine_lfo
// Three phase-accumulator sine LFOs driven by knob and control-voltage readings.
// ----------------------------------------------------------------------------
//
//  Port      Direction  Moves
//  req_chan  in         one frame tick: three knob and three CV readings
//  rsp_chan  out        one result: three DAC codes and three LED states
//  csr_*     in         write of the rate_gain register
//
//  Each tick runs on the bit-serial multiplier, which retires one bit a cycle
//  over four products per channel (knob squared, knob cubed, CV squared, gain).
//  Reset is synchronous; it clears the phases and loads rate_gain with 4096.
//  A new tick is taken while the previous result still waits on rsp_chan.
//  A stalled result holds the block in its final state until the transfer.
//
module three_channel_sine_lfo #(
   parameter int PHASE_BITS      = 24,
   parameter int SINE_TABLE_BITS = 10,
   parameter int CHANNEL_COUNT   = 3
) (
   input  logic                           clock,
   input  logic                           reset,
   tcsl_req_if.sink                       req_chan,
   tcsl_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [tcsl_pkg::GAIN_BITS-1:0] csr_wr_data
);

   localparam int SB       = tcsl_pkg::SAMPLE_BITS;
   localparam int NCH      = tcsl_pkg::IN_CHANNELS;
   localparam int CB       = tcsl_pkg::CHAN_BITS;
   localparam int ACTIVE   = (CHANNEL_COUNT < NCH) ? CHANNEL_COUNT : NCH;
   localparam int INC_BITS = tcsl_pkg::INC_BITS;
   localparam int SUM_BITS = ((PHASE_BITS + 1 > INC_BITS) ? PHASE_BITS + 1 : INC_BITS) + 1;
   localparam logic [CB-1:0]       LAST_CHAN = CB'(ACTIVE - 1);
   localparam logic [SUM_BITS-1:0] ONE_TURN  = SUM_BITS'(1) << PHASE_BITS;

   tcsl_pkg::state_type   state_ff;
   tcsl_pkg::state_type   state_in;
   tcsl_pkg::mul_req_type mul_req;
   tcsl_pkg::mul_rsp_type mul_rsp;

   logic [CB-1:0]                   chan_ff;
   logic [CB-1:0]                   chan_in;
   logic [tcsl_pkg::GAIN_BITS-1:0]  gain_ff;
   logic [tcsl_pkg::GAIN_BITS-1:0]  gain_in;
   logic [tcsl_pkg::RATE_BITS-1:0]  rate_ff;
   logic [tcsl_pkg::RATE_BITS-1:0]  rate_in;
   logic [tcsl_pkg::RATE_BITS-1:0]  rate_sum;
   logic [PHASE_BITS:0]             phase_ff [NCH];
   logic [PHASE_BITS:0]             phase_in [NCH];
   logic [SB-1:0]                   knob_ff [NCH];
   logic [SB-1:0]                   knob_in [NCH];
   logic [SB-1:0]                   volt_ff [NCH];
   logic [SB-1:0]                   volt_in [NCH];
   logic [SB-1:0]                   dac_ff [NCH];
   logic [SB-1:0]                   dac_in [NCH];
   logic [SB-1:0]                   out_dac_ff [NCH];
   logic [SB-1:0]                   out_dac_in [NCH];
   logic [NCH-1:0]                  out_led_ff;
   logic [NCH-1:0]                  out_led_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            sine_start;
   logic [SB-1:0]                   sine_dac;
   logic [SB-1:0]                   knob_sel;
   logic [SB-1:0]                   volt_sel;
   logic [SB-1:0]                   cv_mag;
   logic [SUM_BITS-1:0]             phase_sum;
   logic                            out_free;

   tcsl_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   tcsl_sine #(
      .PHASE_BITS      (PHASE_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_sine (
      .clock    (clock),
      .start    (sine_start),
      .phase    (phase_ff[chan_ff][PHASE_BITS-1:0]),
      .dac_code (sine_dac)
   );

   assign knob_sel = knob_ff[chan_ff];
   assign volt_sel = volt_ff[chan_ff];
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign gain_in  = csr_wr_en ? csr_wr_data : gain_ff;

   always_comb begin
      if (volt_sel[SB-1]) begin
         cv_mag = {1'b0, volt_sel[SB-2:0]};
      end else begin
         cv_mag = tcsl_pkg::HALF_SCALE - volt_sel;
      end
      rate_sum  = rate_ff + mul_rsp.product[tcsl_pkg::SQUARE_SHIFT +: tcsl_pkg::RATE_BITS];
      phase_sum = SUM_BITS'(phase_ff[chan_ff])
                + SUM_BITS'(mul_rsp.product[tcsl_pkg::MUL_P_BITS-1:tcsl_pkg::SCALE_SHIFT]);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tcsl_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               state_in = tcsl_pkg::ST_LAUNCH;
            end
         end
         tcsl_pkg::ST_LAUNCH: begin
            state_in = tcsl_pkg::ST_SQUARE_K;
         end
         tcsl_pkg::ST_SQUARE_K: begin
            if (mul_rsp.done) begin
               state_in = tcsl_pkg::ST_CUBE_K;
            end
         end
         tcsl_pkg::ST_CUBE_K: begin
            if (mul_rsp.done) begin
               state_in = tcsl_pkg::ST_SQUARE_V;
            end
         end
         tcsl_pkg::ST_SQUARE_V: begin
            if (mul_rsp.done) begin
               state_in = tcsl_pkg::ST_SCALE;
            end
         end
         tcsl_pkg::ST_SCALE: begin
            if (mul_rsp.done) begin
               state_in = (chan_ff == LAST_CHAN) ? tcsl_pkg::ST_DELIVER : tcsl_pkg::ST_LAUNCH;
            end
         end
         tcsl_pkg::ST_DELIVER: begin
            if (out_free) begin
               state_in = tcsl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcsl_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mul_req.start = 1'b0;
      mul_req.a     = tcsl_pkg::MUL_A_BITS'(knob_sel);
      mul_req.b     = tcsl_pkg::MUL_B_BITS'(knob_sel);
      sine_start    = 1'b0;
      chan_in       = chan_ff;
      rate_in       = rate_ff;
      phase_in      = phase_ff;
      knob_in       = knob_ff;
      volt_in       = volt_ff;
      dac_in        = dac_ff;
      out_dac_in    = out_dac_ff;
      out_led_in    = out_led_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         tcsl_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               knob_in[0] = req_chan.knob_a;
               knob_in[1] = req_chan.knob_b;
               knob_in[2] = req_chan.knob_c;
               volt_in[0] = req_chan.volt_a;
               volt_in[1] = req_chan.volt_b;
               volt_in[2] = req_chan.volt_c;
               chan_in    = '0;
            end
         end
         tcsl_pkg::ST_LAUNCH: begin
            mul_req.start = 1'b1;
            sine_start    = 1'b1;
         end
         tcsl_pkg::ST_SQUARE_K: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = mul_rsp.product[tcsl_pkg::MUL_A_BITS-1:0];
            end
         end
         tcsl_pkg::ST_CUBE_K: begin
            if (mul_rsp.done) begin
               rate_in = tcsl_pkg::RATE_BITS'(mul_rsp.product[tcsl_pkg::CUBE_SHIFT +: SB]);
               mul_req.start = 1'b1;
               mul_req.a     = tcsl_pkg::MUL_A_BITS'(cv_mag);
               mul_req.b     = tcsl_pkg::MUL_B_BITS'(cv_mag);
            end
         end
         tcsl_pkg::ST_SQUARE_V: begin
            if (mul_rsp.done) begin
               mul_req.start = 1'b1;
               mul_req.a     = tcsl_pkg::MUL_A_BITS'(gain_ff);
               mul_req.b     = rate_sum;
            end
         end
         tcsl_pkg::ST_SCALE: begin
            if (mul_rsp.done) begin
               if (phase_sum > ONE_TURN) begin
                  phase_in[chan_ff] = '0;
               end else begin
                  phase_in[chan_ff] = phase_sum[PHASE_BITS:0];
               end
               dac_in[chan_ff] = sine_dac;
               chan_in         = chan_ff + CB'(1);
            end
         end
         tcsl_pkg::ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               for (int c = 0; c < NCH; c++) begin
                  out_dac_in[c] = (c < ACTIVE) ? dac_ff[c] : tcsl_pkg::DAC_MID;
                  out_led_in[c] = knob_ff[c] > tcsl_pkg::HALF_SCALE;
               end
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcsl_pkg::ST_IDLE;
         chan_ff      <= '0;
         gain_ff      <= tcsl_pkg::GAIN_RESET;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NCH; c++) begin
            phase_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         chan_ff      <= chan_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      rate_ff    <= rate_in;
      knob_ff    <= knob_in;
      volt_ff    <= volt_in;
      dac_ff     <= dac_in;
      out_dac_ff <= out_dac_in;
      out_led_ff <= out_led_in;
   end

   assign req_chan.ready = (state_ff == tcsl_pkg::ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.dac_a = out_dac_ff[0];
   assign rsp_chan.dac_b = out_dac_ff[1];
   assign rsp_chan.dac_c = out_dac_ff[2];
   assign rsp_chan.led_a = out_led_ff[0];
   assign rsp_chan.led_b = out_led_ff[1];
   assign rsp_chan.led_c = out_led_ff[2];

   a_done_in_mul_state: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> (state_ff == tcsl_pkg::ST_SQUARE_K || state_ff == tcsl_pkg::ST_CUBE_K
                        || state_ff == tcsl_pkg::ST_SQUARE_V || state_ff == tcsl_pkg::ST_SCALE))
      else $error("Multiplier finished outside a multiply step.");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      SUM_BITS'(phase_ff[0]) <= ONE_TURN)
      else $error("Channel phase went past one full turn.");

   a_deliver: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcsl_pkg::ST_DELIVER && out_free)
         |=> (rsp_valid_ff && state_ff == tcsl_pkg::ST_IDLE))
      else $error("Finished tick was not presented as a result transfer.");

endmodule
